FILE: design/mbps_pkg.sv
// Package for the masked byte pattern scanner.
// Holds the word types of both channels, the register index codes and reset values.
// No dependencies.
package mbps_pkg;

	// Default signature capacity in bytes.
	localparam int MAX_PATTERN_BYTES_DEF = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW    = 3'd0,
		CFG_PATTERN_HIGH   = 3'd1,
		CFG_CARE_MASK      = 3'd2,
		CFG_PATTERN_LENGTH = 3'd3,
		CFG_MATCH_LIMIT    = 3'd4,
		CFG_BASE_ADDRESS   = 3'd5
	} cfg_reg_t;

	localparam logic [15:0] CARE_MASK_RST      = 16'hFFFF;
	localparam logic [4:0]  PATTERN_LENGTH_RST = 5'd16;

	// One input word: a memory byte plus its framing flags.
	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
		logic       stop_request;
	} item_t;

	// One result word: a match report or the closing done word.
	typedef struct packed {
		logic        match_found;
		logic [63:0] match_address;
		logic [31:0] match_count;
		logic        scan_done;
	} result_t;

endpackage

FILE: design/masked_byte_pattern_scanner.sv
// Top level of the masked byte pattern scanner.
// Window, compare, counters, configuration registers and output queue; uses mbps_pkg.
//
// Usage:
// - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; writes one
//   register per word. Unknown indexes are dropped. Write only while the scanner is idle.
// - Item channel (item_valid/item_ready/item): one memory byte per word, in address
//   order starting at base_address. last_byte closes the scan; stop_request halts it
//   before that byte is examined.
// - Result channel (result_valid/result_ready/result): a match word carries the match
//   address and running count; the done word (match_found 0, address 0) ends a scan.
//   A byte that both matches and closes the scan gives two words, match first.
// - Result words are registered into the result queue when their byte is accepted.
// - Throughput: one byte per cycle while item_ready is high. The compare of the whole
//   window against the signature plus the address add are combinational, between the
//   state registers and a four-entry result queue.
// - Stall: the queue keeps taking bytes while at least two entries are free, so a
//   stalled receiver costs nothing until fewer than two are free; then item_ready drops.
// - Reset: config registers return to their defaults (care mask all ones, length 16),
//   the window, counters and halt flag clear, and the queue empties.
module masked_byte_pattern_scanner #(
	parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  mbps_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output mbps_pkg::result_t                 result
);
	import mbps_pkg::*;

	localparam int IDX_W     = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W     = 2;
	localparam int CNT_W     = 3;
	localparam logic [4:0] MAX_LEN = 5'(MAX_PATTERN_BYTES);

	// ---------------- configuration registers ----------------
	logic [63:0] pattern_low_q;
	logic [63:0] pattern_high_q;
	logic [15:0] care_mask_q;
	logic [4:0]  pattern_length_q;
	logic [31:0] match_limit_q;
	logic [63:0] base_address_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= CARE_MASK_RST;
			pattern_length_q <= PATTERN_LENGTH_RST;
			match_limit_q    <= '0;
			base_address_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				CFG_CARE_MASK:      care_mask_q      <= cfg_data[15:0];
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				CFG_MATCH_LIMIT:    match_limit_q    <= cfg_data[31:0];
				CFG_BASE_ADDRESS:   base_address_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- scan state ----------------
	logic [7:0]  win_q [MAX_PATTERN_BYTES];   // win_q[0] is the newest byte
	logic [63:0] seen_q;
	logic [31:0] cnt_q;
	logic        halted_q;

	logic        item_fire;
	logic        halted_eff;
	logic [7:0]  win_new [MAX_PATTERN_BYTES];
	logic [4:0]  len_eff;
	logic [127:0] sig_vec;
	logic        hit;
	logic [63:0] seen_new;
	logic        enough_seen;
	logic        is_match;
	logic [31:0] cnt_new;
	logic        limit_hit;
	logic [63:0] match_addr;

	assign item_fire  = item_valid && item_ready;
	assign halted_eff = halted_q || item.stop_request;
	assign len_eff    = (pattern_length_q > MAX_LEN) ? MAX_LEN : pattern_length_q;
	assign sig_vec    = {pattern_high_q, pattern_low_q};

	always_comb begin
		win_new[0] = item.byte_value;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			win_new[k] = win_q[k-1];
		end
	end

	// Signature byte i lines up with the byte len-1-i steps back; wildcards skip.
	always_comb begin
		logic [4:0] idx;
		hit = 1'b1;
		idx = '0;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			idx = 5'(len_eff - 5'd1 - 5'(i));
			if ((5'(i) < len_eff) && care_mask_q[i] &&
			    (win_new[idx[IDX_W-1:0]] != sig_vec[8*i +: 8])) begin
				hit = 1'b0;
			end
		end
	end

	assign seen_new    = (&seen_q) ? seen_q : seen_q + 64'd1;
	assign enough_seen = (|seen_new[63:5]) || (seen_new[4:0] >= len_eff);
	assign is_match    = !halted_eff && (len_eff != 5'd0) && enough_seen && hit;
	assign cnt_new     = (is_match && !(&cnt_q)) ? cnt_q + 32'd1 : cnt_q;
	assign limit_hit   = is_match && (match_limit_q != 32'd0) && (cnt_new >= match_limit_q);
	assign match_addr  = base_address_q + seen_new - 64'(len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
				win_q[k] <= '0;
			end
			seen_q   <= '0;
			cnt_q    <= '0;
			halted_q <= 1'b0;
		end else if (item_fire) begin
			if (item.last_byte) begin
				// done word closes the scan; next byte starts fresh
				for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
					win_q[k] <= '0;
				end
				seen_q   <= '0;
				cnt_q    <= '0;
				halted_q <= 1'b0;
			end else begin
				if (!halted_eff) begin
					for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
						win_q[k] <= win_new[k];
					end
					seen_q <= seen_new;
				end
				cnt_q    <= cnt_new;
				halted_q <= halted_eff || limit_hit;
			end
		end
	end

	// ---------------- result queue ----------------
	result_t            fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]   fifo_cnt_q;
	logic               pop;
	logic               wr_match;
	logic               wr_done;
	logic [1:0]         wr_n;
	result_t            match_word;
	result_t            done_word;

	assign wr_match = item_fire && is_match;
	assign wr_done  = item_fire && item.last_byte;
	assign wr_n     = {1'b0, wr_match} + {1'b0, wr_done};

	assign match_word = '{match_found: 1'b1, match_address: match_addr,
	                      match_count: cnt_new, scan_done: 1'b0};
	assign done_word  = '{match_found: 1'b0, match_address: 64'd0,
	                      match_count: cnt_new, scan_done: 1'b1};

	assign item_ready   = (fifo_cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign result_valid = (fifo_cnt_q != '0);
	assign result       = fifo_q[rptr_q];
	assign pop          = result_valid && result_ready;

	always_ff @(posedge clk) begin
		if (wr_match) begin
			fifo_q[wptr_q] <= match_word;
			if (wr_done) begin
				fifo_q[PTR_W'(wptr_q + 1'b1)] <= done_word;
			end
		end else if (wr_done) begin
			fifo_q[wptr_q] <= done_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			rptr_q     <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wptr_q     <= PTR_W'(wptr_q + wr_n);
			rptr_q     <= PTR_W'(rptr_q + {1'b0, pop});
			fifo_cnt_q <= CNT_W'(fifo_cnt_q + CNT_W'(wr_n) - CNT_W'(pop));
		end
	end

	// ---------------- checks ----------------
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_halted_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(item_fire && halted_q) |-> !wr_match)
		else $error("match reported while halted");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		wr_done |=> (seen_q == '0) && (cnt_q == '0) && !halted_q)
		else $error("scan state not cleared after done");

	a_match_counts: assert property (@(posedge clk) disable iff (!arst_n)
		wr_match |-> (cnt_new != '0))
		else $error("match word with zero count");

endmodule
